>>> rtl/hctb_pkg.sv
// Shared types and constants of the Huffman code table builder.
// Depends on nothing; imported by all files but hctb_ram.
package hctb_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int CODE_LEN_W  = 6;
    localparam int CODE_BITS_W = 48;
    localparam int STATUS_W    = 2;

    // func field codes
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // status codes of a result beat
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_NO_TABLE = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                func;
        logic [SYMBOL_W-1:0] data_byte;
        logic                block_end;
    } t_in_item;

    typedef struct packed {
        logic                   entry_valid;
        logic [SYMBOL_W-1:0]    symbol;
        logic [CODE_LEN_W-1:0]  code_length;
        logic [CODE_BITS_W-1:0] code_bits;
        logic                   last_entry;
        t_status                status;
    } t_out_item;

    // classified command from the front end to the engine
    typedef enum logic {
        CMD_COUNT = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op             op;
        logic [SYMBOL_W-1:0] data_byte;
        logic                block_end;
    } t_cmd;

endpackage

>>> rtl/hctb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hctb_front.sv
// Front end: accepts input beats, classifies them into commands, queues two.
// Depends on hctb_pkg.
module hctb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  hctb_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output hctb_pkg::t_cmd    o_cmd
);
    import hctb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push_ok;
    logic       pop_ok;

    // classify: drop block_end on read requests
    always_comb begin
        cls.op        = (i_in_item.func == FUNC_READ) ? CMD_READ : CMD_COUNT;
        cls.data_byte = i_in_item.data_byte;
        cls.block_end = i_in_item.block_end & (i_in_item.func == FUNC_DATA);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push & ~o_full;
    assign pop_ok      = o_cmd_valid & i_cmd_ready;

    // advance the queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_q[r_wp] <= cls;
                r_wp      <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/hctb_resq.sv
// Result queue: two-entry buffer between the engine and the result port.
// Depends on hctb_pkg.
module hctb_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hctb_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output hctb_pkg::t_out_item o_item
);
    import hctb_pkg::*;

    t_out_item  r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_q[r_rp];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    // advance the queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_q[r_wp] <= i_item;
                r_wp      <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/hctb_engine.sv
// Back end: symbol counting, tree build by scan-and-merge, depth-first leaf
// ordering and code readout. Depends on hctb_pkg and hctb_ram.
module hctb_engine #(
    parameter int ALPHABET_SIZE   = 256,
    parameter int NODE_COUNT      = 511,
    parameter int WEIGHT_WIDTH    = 32,
    parameter int MAX_CODE_LENGTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  hctb_pkg::t_cmd     i_cmd,
    input  logic               i_res_full,
    output logic               o_res_valid,
    output hctb_pkg::t_out_item o_res
);
    import hctb_pkg::*;

    localparam int NW         = $clog2(NODE_COUNT);
    localparam int HALF_NODES = (NODE_COUNT + 1) / 2;
    localparam int MAX_LEAVES = (ALPHABET_SIZE < HALF_NODES) ? ALPHABET_SIZE : HALF_NODES;
    localparam int LW         = $clog2(MAX_LEAVES);
    localparam int AW         = $clog2(ALPHABET_SIZE);
    localparam int WW         = WEIGHT_WIDTH;
    localparam int MW         = MAX_CODE_LENGTH;
    localparam int SW         = $clog2(MAX_CODE_LENGTH + 1);
    localparam logic [WW-1:0] WEIGHT_MAX = '1;

    typedef struct packed {
        logic          active;
        logic [WW-1:0] weight;
    } t_wword;

    typedef struct packed {
        logic          root;
        logic [NW-1:0] parent;
        logic          side;
    } t_pword;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_SLOT,
        S_CNT_INC,
        S_BUILD,
        S_SCAN,
        S_MRG_A,
        S_MRG_B,
        S_MRG_N,
        S_DFS_NODE,
        S_DFS_POP,
        S_DFS_CH,
        S_RD_ORD,
        S_RD_CLIMB
    } t_state;

    t_state                   r_state;
    logic [ALPHABET_SIZE-1:0] r_slot_vld;
    logic [NW-1:0]            r_distinct;
    logic [NW-1:0]            r_rp;
    logic                     r_ready;
    logic                     r_ovf;
    logic [SYMBOL_W-1:0]      r_byte;
    logic                     r_last;
    logic [LW-1:0]            r_slot;
    logic [NW-1:0]            r_n;
    logic [NW-1:0]            r_scan_addr;
    logic                     r_scan_pend;
    logic [NW-1:0]            r_scan_idx;
    logic [NW-1:0]            r_a;
    logic [NW-1:0]            r_b;
    logic [WW-1:0]            r_wa;
    logic [WW-1:0]            r_wb;
    logic                     r_a_vld;
    logic                     r_b_vld;
    logic [NW-1:0]            r_cur;
    logic [LW-1:0]            r_top;
    logic [LW-1:0]            r_cnt;
    logic [LW-1:0]            r_leaf;
    logic [NW-1:0]            r_depth;
    logic [MW-1:0]            r_code;
    logic                     r_res_valid;
    t_out_item                r_res;

    // memory ports
    logic                  slot_we;
    logic [AW-1:0]         slot_waddr;
    logic [AW-1:0]         slot_raddr;
    logic [LW-1:0]         slot_rdata;
    logic                  sym_we;
    logic [SYMBOL_W-1:0]   sym_rdata;
    logic                  w_we;
    logic [NW-1:0]         w_waddr;
    t_wword                w_wdata;
    logic [NW-1:0]         w_raddr;
    t_wword                w_rdata;
    logic                  p_we;
    logic [NW-1:0]         p_waddr;
    t_pword                p_wdata;
    logic [NW-1:0]         p_raddr;
    t_pword                p_rdata;
    logic                  ch_we;
    logic [2*NW-1:0]       ch_rdata;
    logic                  st_we;
    logic [LW-1:0]         st_raddr;
    logic [NW-1:0]         st_rdata;
    logic                  ord_we;
    logic [LW-1:0]         ord_rdata;

    logic                  accept;
    logic                  in_range;
    logic [AW-1:0]         byte_idx;
    logic [WW:0]           sum_raw;
    logic [WW-1:0]         sum_sat;
    logic                  merge_done;
    logic                  cur_leaf;
    logic [LW-1:0]         n_leaf;
    logic                  single;
    logic                  trunc;
    logic [SW-1:0]         len_fin;
    logic [MW-1:0]         code_fin;
    logic [63:0]           code_ext;
    logic [7:0]            len_ext;
    t_out_item             rec;

    assign o_cmd_ready = (r_state == S_IDLE)
                       & ((i_cmd.op == CMD_COUNT) | (~i_res_full & ~r_res_valid));
    assign accept      = o_cmd_ready & i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign byte_idx   = r_byte[AW-1:0];
    assign in_range   = 32'(r_byte) < ALPHABET_SIZE;
    assign sum_raw    = {1'b0, r_wa} + {1'b0, r_wb};
    assign sum_sat    = sum_raw[WW] ? WEIGHT_MAX : sum_raw[WW-1:0];
    assign merge_done = ((NW+1)'(r_n) + (NW+1)'(2)) == {r_distinct, 1'b0};
    assign cur_leaf   = r_cur < r_distinct;
    assign single     = (r_distinct == NW'(1));

    // pick the leaf for a readout; an out-of-range order entry falls back to leaf 0
    always_comb begin
        n_leaf = r_leaf;
        if (r_state == S_RD_ORD) begin
            if (single || (NW'(ord_rdata) >= r_distinct)) begin
                n_leaf = '0;
            end else begin
                n_leaf = ord_rdata;
            end
        end
    end

    // finish a code record: clip to the length limit, right-align the code
    always_comb begin
        trunc    = 1'b0;
        len_fin  = SW'(1);
        code_fin = '0;
        if (!single) begin
            trunc = 32'(r_depth) > MAX_CODE_LENGTH;
            if (trunc) begin
                len_fin  = SW'(MW);
                code_fin = r_code;
            end else begin
                len_fin  = SW'(r_depth);
                code_fin = r_code >> (SW'(MW) - len_fin);
            end
        end
        code_ext           = 64'(code_fin);
        len_ext            = 8'(len_fin);
        rec.entry_valid    = 1'b1;
        rec.symbol         = sym_rdata;
        rec.code_length    = len_ext[CODE_LEN_W-1:0];
        rec.code_bits      = code_ext[CODE_BITS_W-1:0];
        rec.last_entry     = (r_rp + NW'(1)) == r_distinct;
        rec.status         = (r_ovf | trunc) ? STATUS_OVERFLOW : STATUS_OK;
    end

    // steer the memory ports by state
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = byte_idx;
        slot_raddr = i_cmd.data_byte[AW-1:0];
        sym_we     = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_n;
        w_wdata    = '{active: 1'b1, weight: sum_sat};
        w_raddr    = r_scan_addr;
        p_we       = 1'b0;
        p_waddr    = r_n;
        p_wdata    = '{root: 1'b1, parent: '0, side: 1'b0};
        p_raddr    = NW'(n_leaf);
        ch_we      = 1'b0;
        st_we      = 1'b0;
        st_raddr   = r_top - LW'(1);
        ord_we     = 1'b0;
        unique case (r_state)
            S_CNT_SLOT: begin
                w_raddr = NW'(slot_rdata);
                if (in_range && !r_slot_vld[byte_idx]
                        && (32'(r_distinct) < MAX_LEAVES)) begin
                    slot_we = 1'b1;
                    sym_we  = 1'b1;
                    w_we    = 1'b1;
                    w_waddr = r_distinct;
                    w_wdata = '{active: 1'b1, weight: WW'(1)};
                end
            end
            S_CNT_INC: begin
                w_waddr = NW'(r_slot);
                w_wdata = '{active: 1'b1, weight: w_rdata.weight + WW'(1)};
                w_we    = (w_rdata.weight != WEIGHT_MAX);
            end
            S_MRG_A: begin
                w_we    = 1'b1;
                w_waddr = r_a;
                w_wdata = '{active: 1'b0, weight: r_wa};
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdata = '{root: 1'b0, parent: r_n, side: 1'b0};
                ch_we   = 1'b1;
            end
            S_MRG_B: begin
                w_we    = 1'b1;
                w_waddr = r_b;
                w_wdata = '{active: 1'b0, weight: r_wb};
                p_we    = 1'b1;
                p_waddr = r_b;
                p_wdata = '{root: 1'b0, parent: r_n, side: 1'b1};
            end
            S_MRG_N: begin
                w_we = 1'b1;
                p_we = 1'b1;
            end
            S_DFS_NODE: begin
                ord_we = cur_leaf;
            end
            S_DFS_CH: begin
                st_we = 1'b1;
            end
            S_RD_CLIMB: begin
                p_raddr = p_rdata.parent;
            end
            default: begin
            end
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot_vld  <= '0;
            r_distinct  <= '0;
            r_rp        <= '0;
            r_ready     <= 1'b0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_leaf      <= n_leaf;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd.op == CMD_COUNT) begin
                            // first byte after a build starts a new block
                            if (r_ready) begin
                                r_slot_vld <= '0;
                                r_distinct <= '0;
                                r_rp       <= '0;
                                r_ready    <= 1'b0;
                                r_ovf      <= 1'b0;
                            end
                            r_byte  <= i_cmd.data_byte;
                            r_last  <= i_cmd.block_end;
                            r_state <= S_CNT_SLOT;
                        end else if (!r_ready) begin
                            r_res_valid <= 1'b1;
                            r_res       <= '{entry_valid: 1'b0, symbol: '0,
                                             code_length: '0, code_bits: '0,
                                             last_entry: 1'b0,
                                             status: STATUS_NO_TABLE};
                        end else if (r_rp >= r_distinct) begin
                            r_res_valid <= 1'b1;
                            r_res       <= '{entry_valid: 1'b0, symbol: '0,
                                             code_length: '0, code_bits: '0,
                                             last_entry: 1'b1,
                                             status: r_ovf ? STATUS_OVERFLOW
                                                           : STATUS_OK};
                        end else begin
                            r_state <= S_RD_ORD;
                        end
                    end
                end
                S_CNT_SLOT: begin
                    if (in_range && r_slot_vld[byte_idx]) begin
                        r_slot  <= slot_rdata;
                        r_state <= S_CNT_INC;
                    end else begin
                        if (in_range && (32'(r_distinct) < MAX_LEAVES)) begin
                            r_slot_vld[byte_idx] <= 1'b1;
                            r_distinct           <= r_distinct + NW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= r_last ? S_BUILD : S_IDLE;
                    end
                end
                S_CNT_INC: begin
                    if (w_rdata.weight == WEIGHT_MAX) begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= r_last ? S_BUILD : S_IDLE;
                end
                S_BUILD: begin
                    r_ready     <= 1'b1;
                    r_rp        <= '0;
                    r_n         <= r_distinct;
                    r_scan_addr <= '0;
                    r_scan_pend <= 1'b0;
                    r_a_vld     <= 1'b0;
                    r_b_vld     <= 1'b0;
                    r_state     <= (r_distinct < NW'(2)) ? S_IDLE : S_SCAN;
                end
                S_SCAN: begin
                    // keep the two smallest active keys; ties go to the lower index
                    if (r_scan_pend && w_rdata.active) begin
                        if (!r_a_vld || (w_rdata.weight < r_wa)) begin
                            r_b     <= r_a;
                            r_wb    <= r_wa;
                            r_b_vld <= r_a_vld;
                            r_a     <= r_scan_idx;
                            r_wa    <= w_rdata.weight;
                            r_a_vld <= 1'b1;
                        end else if (!r_b_vld || (w_rdata.weight < r_wb)) begin
                            r_b     <= r_scan_idx;
                            r_wb    <= w_rdata.weight;
                            r_b_vld <= 1'b1;
                        end
                    end
                    if (r_scan_addr < r_n) begin
                        r_scan_pend <= 1'b1;
                        r_scan_idx  <= r_scan_addr;
                        r_scan_addr <= r_scan_addr + NW'(1);
                    end else begin
                        r_scan_pend <= 1'b0;
                        if (!r_scan_pend) begin
                            r_state <= S_MRG_A;
                        end
                    end
                end
                S_MRG_A: begin
                    r_state <= S_MRG_B;
                end
                S_MRG_B: begin
                    r_state <= S_MRG_N;
                end
                S_MRG_N: begin
                    if (sum_raw[WW]) begin
                        r_ovf <= 1'b1;
                    end
                    r_n         <= r_n + NW'(1);
                    r_scan_addr <= '0;
                    r_scan_pend <= 1'b0;
                    r_a_vld     <= 1'b0;
                    r_b_vld     <= 1'b0;
                    if (merge_done) begin
                        r_cur   <= r_n;
                        r_top   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DFS_NODE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_DFS_NODE: begin
                    if (cur_leaf) begin
                        r_cnt <= r_cnt + LW'(1);
                        if (r_top == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_top   <= r_top - LW'(1);
                            r_state <= S_DFS_POP;
                        end
                    end else begin
                        r_state <= S_DFS_CH;
                    end
                end
                S_DFS_POP: begin
                    r_cur   <= st_rdata;
                    r_state <= S_DFS_NODE;
                end
                S_DFS_CH: begin
                    // hold the right child, descend left at once
                    r_top   <= r_top + LW'(1);
                    r_cur   <= ch_rdata[2*NW-1:NW];
                    r_state <= S_DFS_NODE;
                end
                S_RD_ORD: begin
                    r_depth <= '0;
                    r_code  <= '0;
                    r_state <= S_RD_CLIMB;
                end
                S_RD_CLIMB: begin
                    if (single || p_rdata.root) begin
                        r_res_valid <= 1'b1;
                        r_res       <= rec;
                        r_rp        <= r_rp + NW'(1);
                        r_state     <= S_IDLE;
                    end else begin
                        r_code  <= {p_rdata.side, r_code[MW-1:1]};
                        r_depth <= r_depth + NW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // symbol to leaf slot
    hctb_ram #(.WIDTH(LW), .DEPTH(ALPHABET_SIZE)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_distinct[LW-1:0]),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // leaf slot to symbol
    hctb_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_LEAVES)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (r_distinct[LW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (n_leaf),
        .o_rdata (sym_rdata)
    );

    // node weight with active flag
    hctb_ram #(.WIDTH(WW + 1), .DEPTH(NODE_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // node parent, side and root flag
    hctb_ram #(.WIDTH(NW + 2), .DEPTH(NODE_COUNT)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // children of merged nodes, left in the upper half
    hctb_ram #(.WIDTH(2 * NW), .DEPTH(NODE_COUNT)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (r_n),
        .i_wdata ({r_a, r_b}),
        .i_raddr (r_cur),
        .o_rdata (ch_rdata)
    );

    // traversal stack of pending right children
    hctb_ram #(.WIDTH(NW), .DEPTH(MAX_LEAVES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_top),
        .i_wdata (ch_rdata[NW-1:0]),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // leaves in depth-first order
    hctb_ram #(.WIDTH(LW), .DEPTH(MAX_LEAVES)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_cnt),
        .i_wdata (r_cur[LW-1:0]),
        .i_raddr (r_rp[LW-1:0]),
        .o_rdata (ord_rdata)
    );

endmodule

>>> rtl/huffman_code_table_builder.sv
// Huffman code table builder: a data byte takes a slot lookup in the engine and,
// for a symbol already seen, a weight increment. Each merge of a build scans the
// node weight RAM for the two smallest active nodes; a depth-first walk then
// orders the leaves. A read walks the parent chain from its leaf to the root.
// Two-entry queues on both sides. Synchronous active-low reset clears control
// state only; no memory clearing pass follows reset.
module huffman_code_table_builder #(
    parameter int ALPHABET_SIZE   = 256,
    parameter int NODE_COUNT      = 511,
    parameter int WEIGHT_WIDTH    = 32,
    parameter int MAX_CODE_LENGTH = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  hctb_pkg::t_in_item  i_in_item,
    output logic                o_empty,
    input  logic                i_pop,
    output hctb_pkg::t_out_item o_out_item
);
    import hctb_pkg::*;

    logic      cmd_valid;
    logic      cmd_ready;
    t_cmd      cmd;
    logic      res_valid;
    logic      res_full;
    t_out_item res;

    // accept and classify beats
    hctb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // count, build and read out
    hctb_engine #(
        .ALPHABET_SIZE   (ALPHABET_SIZE),
        .NODE_COUNT      (NODE_COUNT),
        .WEIGHT_WIDTH    (WEIGHT_WIDTH),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_res_full  (res_full),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold results until popped
    hctb_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_full  (res_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_out_item)
    );

endmodule

>>> tb/huffman_code_table_builder_tb.sv
// Testbench for the Huffman code table builder: drives blocks of bytes and read
// requests through the push/pop queues and checks every code record against a
// built-in model of the counting, tree build and depth-first readout. Needs hctb_pkg.
`timescale 1ns / 1ps

module huffman_code_table_builder_tb;
    import hctb_pkg::*;

    localparam int ALPHA      = 256;
    localparam int NODES      = 511;
    localparam int INNER      = 255;
    localparam int MAX_LEN    = 48;
    localparam int NO_PARENT  = 1023;
    localparam int ABSENT     = 511;
    localparam logic [31:0] WT_MAX = 32'hFFFF_FFFF;
    localparam int STALL_LIMIT = 400000;
    localparam int DIRECTED_N = 12;

    logic      i_clk, i_rst_n, i_push, i_pop;
    logic      o_full, o_empty;
    t_in_item  i_in_item;
    t_out_item o_out_item;

    huffman_code_table_builder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_in_item(i_in_item),
        .o_empty(o_empty), .i_pop(i_pop), .o_out_item(o_out_item)
    );

    // Code table model state
    int          slot_of[ALPHA];
    logic [7:0]  leaf_sym[ALPHA];
    logic [31:0] wt[NODES];
    int          tie[NODES];
    bit          act[NODES];
    int          par[NODES];
    bit          side[NODES];
    int          kid_l[INNER], kid_r[INNER];
    int          order[ALPHA];
    int          n_sym, rd_ptr;
    bit          tbl_ready, ovf_seen;

    t_out_item   pending_codes[$];
    int          errors, beats_in, beats_out, records_valid, stall_cnt;
    bit          pop_pattern_all;
    logic [15:0] pop_pattern;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;
    t_row rows[DIRECTED_N];

    function automatic void clear_block();
        for (int s = 0; s < ALPHA; s++) slot_of[s] = ABSENT;
        for (int i = 0; i < NODES; i++) act[i] = 0;
        n_sym = 0; rd_ptr = 0; tbl_ready = 0; ovf_seen = 0;
    endfunction

    function automatic bit key_lt(int i, int j);
        if (wt[i] != wt[j]) return wt[i] < wt[j];
        return tie[i] < tie[j];
    endfunction

    // Merge the two smallest keys until one root, then list leaves left-first
    function automatic void build_tree();
        int k, n, a, b, top, cnt, node;
        int stk[NODES+1];
        logic [32:0] sum;
        k = n_sym; tbl_ready = 1; rd_ptr = 0;
        if (k < 2) begin
            order[0] = 0;
            return;
        end
        for (int i = 0; i < k; i++) begin
            tie[i] = i; act[i] = 1; par[i] = NO_PARENT;
        end
        n = k;
        for (int m = 0; m + 1 < k && n < NODES; m++) begin
            a = NO_PARENT; b = NO_PARENT;
            for (int i = 0; i < n; i++) begin
                if (!act[i]) continue;
                if (a == NO_PARENT || key_lt(i, a)) begin
                    b = a; a = i;
                end else if (b == NO_PARENT || key_lt(i, b)) begin
                    b = i;
                end
            end
            if (a == NO_PARENT || b == NO_PARENT) break;
            act[a] = 0; act[b] = 0;
            par[a] = n; side[a] = 0;
            par[b] = n; side[b] = 1;
            if (n - k < INNER) begin
                kid_l[n-k] = a; kid_r[n-k] = b;
            end
            sum = {1'b0, wt[a]} + {1'b0, wt[b]};
            if (sum > {1'b0, WT_MAX}) begin
                sum = {1'b0, WT_MAX}; ovf_seen = 1;
            end
            wt[n] = sum[31:0]; tie[n] = n; act[n] = 1; par[n] = NO_PARENT;
            n++;
        end
        top = 0; cnt = 0;
        stk[top++] = n - 1;
        while (top > 0) begin
            node = stk[--top];
            if (node < k) begin
                if (cnt < ALPHA) order[cnt++] = node;
            end else if (node - k < INNER && top + 2 <= NODES + 1) begin
                stk[top++] = kid_r[node-k];
                stk[top++] = kid_l[node-k];
            end
        end
    endfunction

    // Advance the model by one input beat; return 1 with the record on a read
    function automatic bit predict_code(input t_in_item it, output t_out_item rec);
        int leaf, depth, len, cur;
        bit trunc;
        bit path[NODES];
        logic [47:0] code;
        rec = '0;
        if (it.func == FUNC_DATA) begin
            if (tbl_ready) clear_block();
            if (slot_of[it.data_byte] != ABSENT) begin
                if (wt[slot_of[it.data_byte]] >= WT_MAX) ovf_seen = 1;
                else wt[slot_of[it.data_byte]]++;
            end else if (n_sym < ALPHA) begin
                slot_of[it.data_byte] = n_sym;
                leaf_sym[n_sym] = it.data_byte;
                wt[n_sym] = 1;
                n_sym++;
            end else begin
                ovf_seen = 1;
            end
            if (it.block_end) build_tree();
            return 0;
        end
        if (!tbl_ready) begin
            rec.status = STATUS_NO_TABLE;
            return 1;
        end
        if (rd_ptr >= n_sym) begin
            rec.last_entry = 1;
            rec.status = ovf_seen ? STATUS_OVERFLOW : STATUS_OK;
            return 1;
        end
        leaf = order[rd_ptr];
        if (leaf >= n_sym) leaf = 0;
        code = '0; trunc = 0;
        if (n_sym == 1) begin
            len = 1;
        end else begin
            depth = 0; cur = leaf;
            while (cur < NODES && par[cur] != NO_PARENT && depth < NODES) begin
                path[depth++] = side[cur];
                cur = par[cur];
            end
            len = depth;
            if (len > MAX_LEN) begin
                len = MAX_LEN; trunc = 1;
            end
            for (int j = 0; j < len; j++) code = {code[46:0], path[depth-1-j]};
        end
        rec.entry_valid = 1;
        rec.symbol = leaf_sym[leaf];
        rec.code_length = len[5:0];
        rec.code_bits = code;
        rec.last_entry = (rd_ptr + 1 == n_sym);
        rec.status = (ovf_seen || trunc) ? STATUS_OVERFLOW : STATUS_OK;
        rd_ptr++;
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Accept side: feed the model, queue the expected record
    t_out_item next_row_want;
    bit        next_row_typed;
    always @(posedge i_clk) begin
        t_out_item rec;
        if (i_rst_n && i_push && !o_full) begin
            beats_in++;
            if (predict_code(i_in_item, rec))
                pending_codes.push_back(next_row_typed ? next_row_want : rec);
        end
    end

    task automatic chk_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: compare each popped beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && i_pop && !o_empty) begin
            beats_out++;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected record %0h", $time, o_out_item);
                errors++;
            end else begin
                w = pending_codes.pop_front();
                if (w.entry_valid) records_valid++;
                chk_field("entry_valid", w.entry_valid, o_out_item.entry_valid);
                chk_field("symbol", w.symbol, o_out_item.symbol);
                chk_field("code_length", w.code_length, o_out_item.code_length);
                chk_field("code_bits", w.code_bits, o_out_item.code_bits);
                chk_field("last_entry", w.last_entry, o_out_item.last_entry);
                chk_field("status", w.status, o_out_item.status);
            end
        end
    end

    // Receiver stall pattern, reshuffled now and then
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) begin
            pop_pattern = 16'($urandom);
            pop_pattern_all = ($urandom_range(0, 2) == 0);
        end
        pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
        i_pop <= pop_pattern_all | pop_pattern[0];
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    int burst_left;

    // Push one beat; bursts of random length, most separated by random gaps
    task automatic send(input t_in_item it, input bit typed = 0, input t_out_item want = '0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_push <= 0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_push <= 1;
        i_in_item <= it;
        next_row_typed = typed;
        next_row_want = want;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
        next_row_typed = 0;
        if (burst_left == 0) i_push <= 0;
    endtask

    task automatic drain();
        i_push <= 0;
        burst_left = 0;
        while (pending_codes.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in_item mk(logic f, logic [7:0] b, logic e);
        t_in_item it;
        it.func = f; it.data_byte = b; it.block_end = e;
        return it;
    endfunction

    function automatic t_out_item rec_of(logic v, logic [7:0] s, logic [5:0] l,
                                         logic last, t_status st);
        t_out_item r;
        r = '0;
        r.entry_valid = v; r.symbol = s; r.code_length = l;
        r.last_entry = last; r.status = st;
        return r;
    endfunction

    // Send one block of bytes over a small random alphabet, then read it out
    task automatic random_block(int max_len, int max_alpha);
        logic [7:0] alpha[$];
        bit seen[ALPHA];
        int len, distinct;
        logic [7:0] b;
        repeat ($urandom_range(1, max_alpha)) alpha.push_back(8'($urandom_range(0, 255)));
        len = $urandom_range(1, max_len);
        distinct = 0;
        for (int i = 0; i < len; i++) begin
            // skew toward the front of the alphabet for uneven weights
            b = alpha[$urandom_range(0, $urandom_range(0, alpha.size() - 1))];
            if (!seen[b]) distinct++;
            seen[b] = 1;
            send(mk(FUNC_DATA, b, i == len - 1));
            if ($urandom_range(0, 19) == 0 && i != len - 1)
                send(mk(FUNC_READ, 8'($urandom), 1'($urandom)));
        end
        repeat (distinct + $urandom_range(0, 2))
            send(mk(FUNC_READ, 8'($urandom), 1'($urandom)));
    endtask

    initial begin
        errors = 0; beats_in = 0; beats_out = 0; records_valid = 0; stall_cnt = 0;
        burst_left = 0; pop_pattern = 16'hFFFF; pop_pattern_all = 1;
        next_row_typed = 0; next_row_want = '0;
        i_rst_n = 0; i_push = 0; i_pop = 0; i_in_item = '0;
        clear_block();
        for (int i = 0; i < NODES; i++) begin
            wt[i] = 0; tie[i] = 0; par[i] = 0; side[i] = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed rows: typed expectations where obvious, model elsewhere
        rows[0]  = '{mk(FUNC_READ, 8'h00, 0), 1, rec_of(0, 0, 0, 0, STATUS_NO_TABLE)};
        rows[1]  = '{mk(FUNC_READ, 8'hFF, 1), 1, rec_of(0, 0, 0, 0, STATUS_NO_TABLE)};
        rows[2]  = '{mk(FUNC_DATA, 8'h00, 1), 0, '0};
        rows[3]  = '{mk(FUNC_READ, 8'h00, 0), 1, rec_of(1, 8'h00, 1, 1, STATUS_OK)};
        rows[4]  = '{mk(FUNC_READ, 8'hAA, 1), 1, rec_of(0, 0, 0, 1, STATUS_OK)};
        rows[5]  = '{mk(FUNC_DATA, 8'hFF, 0), 0, '0};
        rows[6]  = '{mk(FUNC_READ, 8'h55, 0), 1, rec_of(0, 0, 0, 0, STATUS_NO_TABLE)};
        rows[7]  = '{mk(FUNC_DATA, 8'h00, 0), 0, '0};
        rows[8]  = '{mk(FUNC_DATA, 8'hFF, 1), 0, '0};
        rows[9]  = '{mk(FUNC_READ, 8'h00, 0), 0, '0};
        rows[10] = '{mk(FUNC_READ, 8'h00, 0), 0, '0};
        rows[11] = '{mk(FUNC_READ, 8'h00, 0), 1, rec_of(0, 0, 0, 1, STATUS_OK)};
        for (int r = 0; r < DIRECTED_N; r++) send(rows[r].item, rows[r].typed, rows[r].want);
        drain();

        // One full-alphabet block: every byte value once, one twice; read the
        // first quarter of the code list
        for (int s = 0; s < ALPHA; s++) send(mk(FUNC_DATA, 8'(s), 0));
        send(mk(FUNC_DATA, 8'h7F, 1));
        repeat (ALPHA / 4) send(mk(FUNC_READ, 0, 0));
        drain();

        // Random part: mostly well-formed blocks, some raw noise beats
        while (beats_in < 400) begin
            if ($urandom_range(0, 9) < 8) random_block(30, 12);
            else repeat ($urandom_range(1, 6))
                send(mk(1'($urandom), 8'($urandom), 1'($urandom)));
            if ($urandom_range(0, 15) == 0) drain();
        end
        random_block(60, 40);
        drain();

        repeat (200) @(negedge i_clk);
        $display("Covered %0d input beats and %0d records (%0d with a code).",
                 beats_in, beats_out, records_valid);
        if (errors == 0 && pending_codes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/hctb_pkg.sv
rtl/hctb_ram.sv
rtl/hctb_front.sv
rtl/hctb_resq.sv
rtl/hctb_engine.sv
rtl/huffman_code_table_builder.sv
tb/huffman_code_table_builder_tb.sv
